### src/sree_pkg.sv
// Shared widths, codes and result type of the symbol rate exponent encoder.
`default_nettype none

package sree_pkg;

   localparam int OSC_W     = 32;                  // oscillator register
   localparam int RATE_W    = 26;                  // requested rate
   localparam int EXP_W     = 4;                   // exponent field
   localparam int MANT_W    = 20;                  // mantissa field
   localparam int BACK_W    = 32;                  // rate given back
   localparam int VAL_W     = MANT_W + 1;          // mantissa with implied leading one
   localparam int Q_W       = MANT_W + 2;          // quotient bits kept by the divider
   localparam int SH_ZERO   = 38;                  // scale shift at exponent zero
   localparam int SH_BASE   = 39;                  // scale shift is SH_BASE - e above zero
   localparam int DIV_STEPS = RATE_W + SH_BASE;    // dividend bits walked by the divider
   localparam int PROD_W    = OSC_W + 1 + VAL_W;   // shift-add product register

   localparam logic [OSC_W-1:0] OSC_RESET = OSC_W'(40000000);

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic [BACK_W-1:0] rate_back;
      logic [MANT_W-1:0] mantissa;
      logic [EXP_W-1:0]  exponent;
   } rsp_fields_type;

endpackage

`default_nettype wire

### src/symbol_rate_exponent_encoder.sv
// Symbol rate to exponent and mantissa encoder with rate read-back.
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata rate/exp/mant, tuser op
//  rsp      out        rsp_tvalid/tready    tdata exp/mant/rate_back, tuser clamped
//  csr      in         csr_wr_en            csr_wr_data oscillator frequency
//
// An encode walks DIV_STEPS (65) dividend bits in the radix-2 divider, one
// quotient bit a cycle, then the ST_FIN and ST_MSET set-up states and the
// shift-add multiplier and rounding shifter, where the scale shift sh is 38 at
// exponent zero and 39 - e otherwise; ST_DONE then loads the output register
// once it is free. A decode skips the divider and the first set-up state.
// Reset is synchronous and returns the oscillator register to 40 MHz.
// A new beat is taken whenever the core is idle, even while a result waits.
`default_nettype none

module symbol_rate_exponent_encoder #(
   parameter int EXP_MAX = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [25:0] rate_request, [29:26] exponent_in, [49:30] mantissa_in, [55:50] zero
   input  wire logic [55:0] req_tdata,
   // [0] op
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] exponent_out, [23:4] mantissa_out, [55:24] rate_back
   output logic [55:0]      rsp_tdata,
   // [0] clamped
   output logic             rsp_tuser,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int OSC_W  = sree_pkg::OSC_W;
   localparam int RATE_W = sree_pkg::RATE_W;
   localparam int EXP_W  = sree_pkg::EXP_W;
   localparam int MANT_W = sree_pkg::MANT_W;
   localparam int BACK_W = sree_pkg::BACK_W;
   localparam int VAL_W  = sree_pkg::VAL_W;
   localparam int Q_W    = sree_pkg::Q_W;
   localparam int PROD_W = sree_pkg::PROD_W;
   localparam int DCNT_W = $clog2(sree_pkg::DIV_STEPS);
   localparam int MCNT_W = $clog2(VAL_W + sree_pkg::SH_ZERO);
   localparam int SH_W   = $clog2(sree_pkg::SH_BASE + 1);
   localparam int CAP_FIRST = sree_pkg::DIV_STEPS - EXP_MAX;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_MSET = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [OSC_W-1:0]  osc_ff, osc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sree_pkg::rsp_fields_type rsp_ff, rsp_in;
   logic              rsp_clamp_ff, rsp_clamp_in;

   logic [OSC_W-1:0]  dvs_ff, dvs_in;
   logic [RATE_W-1:0] dvd_ff, dvd_in;
   logic [OSC_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic              big_ff, big_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              found_ff, found_in;
   logic [VAL_W-1:0]  cap_t_ff, cap_t_in;
   logic [EXP_W-1:0]  cap_e_ff, cap_e_in;

   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic [MANT_W-1:0] mant_ff, mant_in;
   logic              clamp_ff, clamp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              rnd_ff, rnd_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic [SH_W-1:0]   sh_ff, sh_in;

   logic                div_bit;
   logic [OSC_W+1:0]    trial;
   logic                qbit;
   logic [Q_W-1:0]      q_new;
   logic                big_new;
   logic [Q_W:0]        q_inc;
   logic [VAL_W:0]      q_fin_inc;
   logic                zero_ok;
   logic [OSC_W:0]      hi_sum;
   logic [MCNT_W-1:0]   mul_last;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = rsp_clamp_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      // Restoring division step on the dividend rate followed by zeros.
      div_bit = dvd_ff[RATE_W-1];
      trial   = {1'b0, rem_ff, div_bit} - {2'b00, dvs_ff};
      qbit    = !trial[OSC_W+1];
      q_new   = {q_ff[Q_W-2:0], qbit};
      big_new = big_ff | q_ff[Q_W-1];
      q_inc   = {1'b0, q_new} + (Q_W+1)'(1);

      // Rounded quotient at exponent zero and its range test.
      q_fin_inc = {1'b0, q_ff[VAL_W-1:0]} + (VAL_W+1)'(1);
      zero_ok   = !big_ff && !q_ff[Q_W-1] && (q_ff[VAL_W-1:0] != {VAL_W{1'b1}});

      // Shift-add multiplier: only steps with a count below VAL_W add.
      hi_sum = {1'b0, prod_ff[PROD_W-2:VAL_W]};
      if ((mcnt_ff < MCNT_W'(VAL_W)) && prod_ff[0]) begin
         hi_sum = {1'b0, prod_ff[PROD_W-2:VAL_W]} + {1'b0, dvs_ff};
      end
      mul_last = MCNT_W'(VAL_W) + MCNT_W'(sh_ff) - MCNT_W'(1);

      state_in     = state_ff;
      osc_in       = csr_wr_en ? csr_wr_data : osc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rsp_clamp_in = rsp_clamp_ff;
      dvs_in       = dvs_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      big_in       = big_ff;
      dcnt_in      = dcnt_ff;
      found_in     = found_ff;
      cap_t_in     = cap_t_ff;
      cap_e_in     = cap_e_ff;
      exp_in       = exp_ff;
      mant_in      = mant_ff;
      clamp_in     = clamp_ff;
      prod_in      = prod_ff;
      rnd_in       = rnd_ff;
      mcnt_in      = mcnt_ff;
      sh_in        = sh_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dvs_in   = (osc_ff == '0) ? OSC_W'(1) : osc_ff;
               dvd_in   = req_tdata[RATE_W-1:0];
               rem_in   = '0;
               q_in     = '0;
               big_in   = 1'b0;
               dcnt_in  = '0;
               found_in = 1'b0;
               exp_in   = req_tdata[RATE_W +: EXP_W];
               mant_in  = req_tdata[RATE_W+EXP_W +: MANT_W];
               clamp_in = 1'b0;
               state_in = (req_tuser == sree_pkg::OP_DECODE) ? ST_MSET : ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in  = {dvd_ff[RATE_W-2:0], 1'b0};
            rem_in  = qbit ? trial[OSC_W-1:0] : {rem_ff[OSC_W-2:0], div_bit};
            q_in    = q_new;
            big_in  = big_new;
            dcnt_in = dcnt_ff + DCNT_W'(1);
            // The rounded quotients grow with the scale, so the last one in range
            // belongs to the smallest exponent that fits.
            if ((dcnt_ff >= DCNT_W'(CAP_FIRST)) && !big_new
                && (q_new != {Q_W{1'b1}})) begin
               found_in = 1'b1;
               cap_t_in = q_inc[Q_W-1:1];
               cap_e_in = EXP_W'(DCNT_W'(sree_pkg::DIV_STEPS) - dcnt_ff);
            end
            if (dcnt_ff == DCNT_W'(sree_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (zero_ok) begin
               exp_in   = '0;
               mant_in  = q_fin_inc[VAL_W-1:1];
               clamp_in = 1'b0;
            end else if (found_ff) begin
               exp_in   = cap_e_ff;
               mant_in  = cap_t_ff[VAL_W-1] ? cap_t_ff[MANT_W-1:0] : '0;
               clamp_in = 1'b0;
            end else begin
               exp_in   = EXP_W'(EXP_MAX);
               mant_in  = {MANT_W{1'b1}};
               clamp_in = 1'b1;
            end
            state_in = ST_MSET;
         end
         ST_MSET: begin
            prod_in  = {{(PROD_W-VAL_W){1'b0}}, (exp_ff != '0), mant_ff};
            mcnt_in  = '0;
            rnd_in   = 1'b0;
            sh_in    = (exp_ff == '0) ? SH_W'(sree_pkg::SH_ZERO)
                                      : SH_W'(sree_pkg::SH_BASE) - SH_W'(exp_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = {1'b0, hi_sum, prod_ff[VAL_W-1:1]};
            rnd_in  = prod_ff[0];
            mcnt_in = mcnt_ff + MCNT_W'(1);
            if (mcnt_ff == mul_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in.exponent  = exp_ff;
               rsp_in.mantissa  = mant_ff;
               rsp_in.rate_back = prod_ff[BACK_W-1:0] + BACK_W'(rnd_ff);
               rsp_clamp_in     = clamp_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         osc_ff       <= sree_pkg::OSC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         osc_ff       <= osc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      rsp_clamp_ff <= rsp_clamp_in;
      dvs_ff       <= dvs_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      big_ff       <= big_in;
      dcnt_ff      <= dcnt_in;
      found_ff     <= found_in;
      cap_t_ff     <= cap_t_in;
      cap_e_ff     <= cap_e_in;
      exp_ff       <= exp_in;
      mant_ff      <= mant_in;
      clamp_ff     <= clamp_in;
      prod_ff      <= prod_in;
      rnd_ff       <= rnd_in;
      mcnt_ff      <= mcnt_in;
      sh_ff        <= sh_in;
   end

   // A beat taken means the core is busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("core still ready after taking a beat");

   // A saturated result sits at the top exponent with a full mantissa.
   a_clamp_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clamp_ff) |->
         (rsp_ff.exponent == EXP_W'(EXP_MAX)) && (rsp_ff.mantissa == {MANT_W{1'b1}}))
      else $error("clamped result with unexpected fields");

   // The divider never runs past the last dividend bit.
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff < DCNT_W'(sree_pkg::DIV_STEPS)))
      else $error("divider step count out of range");

   // The multiplier stops exactly after the scale shift.
   a_mul_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (mcnt_ff <= mul_last))
      else $error("multiplier step count out of range");

   // An encoded exponent never exceeds the top exponent.
   a_exp_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (exp_ff <= EXP_W'(EXP_MAX)))
      else $error("encoded exponent above the top exponent");

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench of the symbol rate exponent encoder, with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;

   localparam int EXP_MAX = 15;
   localparam longint unsigned MANT_ONE = 64'd1 << sree_pkg::MANT_W;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 200;

   class rate_scoreboard;
      logic [sree_pkg::OSC_W-1:0] osc_freq;
      sree_pkg::rsp_fields_type   fields_q[$];
      logic                       clamped_q[$];
      int                         mismatches;

      function new();
         osc_freq   = sree_pkg::OSC_RESET;
         mismatches = 0;
      endfunction

      // floor((rate * 2^sh + floor(d/2)) / d), wide enough for every case.
      function logic [63:0] round_scaled(logic [sree_pkg::RATE_W-1:0] rate, int sh,
                                         logic [63:0] d);
         logic [95:0] num;
         num = ({70'd0, rate} << sh) + {32'd0, d >> 1};
         return 64'(num / {32'd0, d});
      endfunction

      function logic [sree_pkg::BACK_W-1:0] rate_of_fields(logic [sree_pkg::EXP_W-1:0] e,
                                                           logic [sree_pkg::MANT_W-1:0] m,
                                                           logic [63:0] d);
         logic [95:0] val;
         int          sh;
         val = {76'd0, m};
         sh  = sree_pkg::SH_ZERO;
         if (e != 0) begin
            val = val + (96'd1 << sree_pkg::MANT_W);
            sh  = sree_pkg::SH_BASE - int'(e);
         end
         val = val * {32'd0, d};
         val = (val + (96'd1 << (sh - 1))) >> sh;
         return val[sree_pkg::BACK_W-1:0];
      endfunction

      function void note_request(logic op, logic [sree_pkg::RATE_W-1:0] rate,
                                 logic [sree_pkg::EXP_W-1:0] e_in,
                                 logic [sree_pkg::MANT_W-1:0] m_in);
         sree_pkg::rsp_fields_type f;
         logic [63:0]              d;
         logic [63:0]              m;
         logic [63:0]              t;
         int                       e;
         logic                     clip;
         d    = (osc_freq == 0) ? 64'd1 : {32'd0, osc_freq};
         clip = 1'b0;
         if (op == sree_pkg::OP_ENCODE) begin
            e = 0;
            m = round_scaled(rate, sree_pkg::SH_ZERO, d);
            while (m >= MANT_ONE && e < EXP_MAX) begin
               e++;
               t = round_scaled(rate, sree_pkg::SH_BASE - e, d);
               m = (t >= MANT_ONE) ? t - MANT_ONE : 64'd0;
            end
            // Still too large at the top exponent: saturate and flag it.
            if (m >= MANT_ONE) begin
               m    = MANT_ONE - 1;
               clip = 1'b1;
            end
         end else begin
            e = int'(e_in);
            m = {44'd0, m_in};
         end
         f.exponent  = sree_pkg::EXP_W'(e);
         f.mantissa  = m[sree_pkg::MANT_W-1:0];
         f.rate_back = rate_of_fields(f.exponent, f.mantissa, d);
         fields_q.push_back(f);
         clamped_q.push_back(clip);
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      endfunction

      function void check_result(logic [55:0] data, logic flag);
         sree_pkg::rsp_fields_type got;
         sree_pkg::rsp_fields_type want;
         logic                     want_clip;
         got = sree_pkg::rsp_fields_type'(data);
         if (fields_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h clamped %b",
                     $time, data, flag);
            mismatches++;
            return;
         end
         want      = fields_q.pop_front();
         want_clip = clamped_q.pop_front();
         if (got.exponent !== want.exponent)
            report("exponent", 64'(want.exponent), 64'(got.exponent));
         if (got.mantissa !== want.mantissa)
            report("mantissa", 64'(want.mantissa), 64'(got.mantissa));
         if (got.rate_back !== want.rate_back)
            report("rate_back", 64'(want.rate_back), 64'(got.rate_back));
         if (flag !== want_clip)
            report("clamped", 64'(want_clip), 64'(flag));
      endfunction

      function int pending();
         return fields_q.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int   send_idle  = 0;
   int   recv_stall = 0;
   bit   hold_start = 1'b0;
   int   hold_left  = 0;

   rate_scoreboard scoreboard = new();

   symbol_rate_exponent_encoder #(
      .EXP_MAX(EXP_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Result side: check every accepted beat, then decide on the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_result(rsp_tdata, rsp_tuser);
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_request(logic op, logic [sree_pkg::RATE_W-1:0] rate,
                               logic [sree_pkg::EXP_W-1:0] e,
                               logic [sree_pkg::MANT_W-1:0] m);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, m, e, rate};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scoreboard.note_request(op, rate, e, m);
   endtask

   task automatic send_random();
      logic [sree_pkg::RATE_W-1:0] rate;
      logic [sree_pkg::EXP_W-1:0]  e;
      logic [sree_pkg::MANT_W-1:0] m;
      logic                        op;
      int                          w;
      op = 1'($urandom_range(1));
      w  = $urandom_range(sree_pkg::RATE_W);
      // Mix full-range, narrow, tiny, power-of-two and all-ones rates so every exponent is hit.
      case ($urandom_range(3))
         0: begin
            rate = sree_pkg::RATE_W'($urandom);
         end
         1: begin
            rate = sree_pkg::RATE_W'($urandom)
                   & ((sree_pkg::RATE_W'(1) << w) - sree_pkg::RATE_W'(1));
         end
         2: begin
            rate = sree_pkg::RATE_W'($urandom_range(255));
         end
         default: begin
            rate = ($urandom_range(3) == 0) ? '1
                   : sree_pkg::RATE_W'(1) << $urandom_range(sree_pkg::RATE_W - 1);
         end
      endcase
      e = sree_pkg::EXP_W'($urandom);
      m = sree_pkg::MANT_W'($urandom);
      if ($urandom_range(7) == 0)
         m = $urandom_range(1) ? '1 : '0;
      send_request(op, rate, e, m);
   endtask

   task automatic run_directed();
      send_request(sree_pkg::OP_ENCODE, 26'd0, 4'd0, 20'd0);
      send_request(sree_pkg::OP_ENCODE, 26'd1, 4'd0, 20'd0);
      send_request(sree_pkg::OP_ENCODE, 26'h3FFFFFF, 4'hF, 20'hFFFFF);
      send_request(sree_pkg::OP_ENCODE, 26'h2AAAAAA, 4'h5, 20'h55555);
      send_request(sree_pkg::OP_ENCODE, 26'h1555555, 4'hA, 20'hAAAAA);
      send_request(sree_pkg::OP_ENCODE, 26'd1000000, 4'd0, 20'd0);
      send_request(sree_pkg::OP_DECODE, 26'd0, 4'd0, 20'd0);
      send_request(sree_pkg::OP_DECODE, 26'h3FFFFFF, 4'd0, 20'hFFFFF);
      send_request(sree_pkg::OP_DECODE, 26'd0, 4'd15, 20'hFFFFF);
      send_request(sree_pkg::OP_DECODE, 26'd0, 4'd15, 20'd0);
      send_request(sree_pkg::OP_DECODE, 26'h1555555, 4'd1, 20'h55555);
      send_request(sree_pkg::OP_DECODE, 26'h2AAAAAA, 4'd8, 20'hAAAAA);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (scoreboard.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The register is only written once the block has handed back every result.
   task automatic set_oscillator(logic [31:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      scoreboard.osc_freq = value;
   endtask

   task automatic run_phase(logic [31:0] osc, int idle_pct, int stall_pct, int count, bit hold);
      set_oscillator(osc);
      send_idle  = idle_pct;
      recv_stall = stall_pct;
      if (hold)
         hold_start = 1'b1;
      repeat (count) send_random();
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      set_oscillator(32'd0);
      run_directed();
      run_phase(32'd40000000, 0, 0, 70, 1'b0);
      run_phase(32'd0, 83, 0, 60, 1'b0);
      run_phase(32'd1, 0, 83, 60, 1'b0);
      run_phase(32'hFFFFFFFF, 19, 19, 60, 1'b0);
      run_phase($urandom, 0, 0, 70, 1'b1);
      run_phase($urandom_range(100000000, 26000000), 83, 0, 70, 1'b0);
      run_phase($urandom_range(1000000, 1), 0, 83, 70, 1'b0);
      run_phase($urandom, 19, 19, 80, 1'b0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
